FILE: rtl/jfs_pkg.sv
// Shared types and constants of the five-point stencil unit.
// Used by the stream interfaces, the output queue, the lane datapath and the top level.
// Depends on nothing.
package jfs_pkg;

	localparam int FIELD_LANES = 8;
	localparam int WORD_W = 32;

	localparam int ROW_VEC_W = 9;
	localparam int ROW_CNT_W = 16;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam int REG_SEL_BIT = 2;

	localparam logic REG_ROW_VECTORS = 1'b0;
	localparam logic REG_ROW_COUNT = 1'b1;

	localparam logic [ROW_VEC_W-1:0] ROW_VECTORS_RST = 9'd64;
	localparam logic [ROW_CNT_W-1:0] ROW_COUNT_RST = 16'd64;

	// Depth of the result queue; a power of two so the pointers wrap naturally.
	localparam int OUT_DEPTH = 8;

	typedef logic signed [WORD_W-1:0] word_t;

	typedef struct packed {
		word_t [FIELD_LANES-1:0] lanes;
		logic last_of_run;
		logic end_of_grid;
	} res_word_t;

	typedef struct packed {
		logic valid;
		res_word_t word;
	} push_t;

endpackage

FILE: rtl/jfs_stream_if.sv
// Stream interfaces of the stencil unit: input vectors and result words.
// Valid/ready handshake; depends on jfs_pkg.
interface jfs_in_if;
	import jfs_pkg::*;

	logic valid;
	logic ready;
	word_t lane0_value;
	word_t lane1_value;
	word_t lane2_value;
	word_t lane3_value;
	word_t lane4_value;
	word_t lane5_value;
	word_t lane6_value;
	word_t lane7_value;

	modport source (
		output valid, lane0_value, lane1_value, lane2_value, lane3_value,
		lane4_value, lane5_value, lane6_value, lane7_value,
		input ready
	);

	modport sink (
		input valid, lane0_value, lane1_value, lane2_value, lane3_value,
		lane4_value, lane5_value, lane6_value, lane7_value,
		output ready
	);
endinterface

interface jfs_out_if;
	import jfs_pkg::*;

	logic valid;
	logic ready;
	word_t lane0_result;
	word_t lane1_result;
	word_t lane2_result;
	word_t lane3_result;
	word_t lane4_result;
	word_t lane5_result;
	word_t lane6_result;
	word_t lane7_result;
	logic last_of_run;
	logic end_of_grid;

	modport source (
		output valid, lane0_result, lane1_result, lane2_result, lane3_result,
		lane4_result, lane5_result, lane6_result, lane7_result,
		last_of_run, end_of_grid,
		input ready
	);

	modport sink (
		input valid, lane0_result, lane1_result, lane2_result, lane3_result,
		lane4_result, lane5_result, lane6_result, lane7_result,
		last_of_run, end_of_grid,
		output ready
	);
endinterface

FILE: rtl/jacobi_five_point_stencil_unit.sv
// Top level of the streaming five-point Jacobi stencil with its two-row line store.
// Depends on jfs_pkg, jfs_stream_if, jfs_lane_math and jfs_out_fifo.
//
//   channel   direction  handshake                    word
//   vec_in    in         valid/ready                  lane0_value..lane7_value
//   vec_out   out        valid/ready                  lane0_result..lane7_result, flags
//   apb       in         psel/penable/pwrite, pready  row_vectors @0x0, row_count @0x4
//
// One vector per cycle is accepted while the output queue has credit; a last-row vector of a
// grid with more than one row yields two words and holds off the next vector, since the queue
// takes one word a cycle. The first word enters the output queue from stage three, and the
// second word follows it in the next cycle from the stage-four register.
// The line store has no reset and needs no clearing pass; position and registers
// reset asynchronously. Output stalls throttle the input through credits on the queue.
module jacobi_five_point_stencil_unit #(
	parameter int MAX_ROW_VECTORS = 256,
	parameter int LANES = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	jfs_in_if.sink                             vec_in,
	jfs_out_if.source                          vec_out,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [jfs_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [jfs_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [jfs_pkg::APB_DATA_W-1:0]     prdata,
	output logic                               pready
);
	import jfs_pkg::*;

	localparam int AW = (MAX_ROW_VECTORS > 1) ? $clog2(MAX_ROW_VECTORS) : 1;
	localparam int PW = ((AW > ROW_VEC_W) ? AW : ROW_VEC_W) + 1;
	localparam int CRED_W = $clog2(OUT_DEPTH + 1);

	typedef logic [LANES-1:0][WORD_W-1:0] vec_t;

	typedef struct packed {
		vec_t older;
		vec_t newer;
	} entry_t;

	// Configuration registers.
	logic [ROW_VEC_W-1:0] row_vectors_q;
	logic [ROW_CNT_W-1:0] row_count_q;
	logic                 cfg_wr;

	// Position and decode of the incoming vector.
	logic [AW-1:0]        col_q;
	logic [ROW_CNT_W-1:0] row_q;
	logic [PW-1:0]        col_inc;
	logic [ROW_CNT_W:0]   row_inc;
	logic                 last_col;
	logic                 last_row;
	logic                 has_a;
	logic                 has_b;
	logic                 is_copy;
	logic [AW-1:0]        rd_b_addr;
	logic [1:0]           add_words;
	word_t                in_lanes [FIELD_LANES];
	vec_t                 in_vec;

	// Flow control.
	logic                 accept;
	logic                 pop;
	logic                 bubble_q;
	logic [CRED_W-1:0]    credit_q;

	// Line store and forwarding.
	entry_t               mem [MAX_ROW_VECTORS];
	entry_t               rd_a_q;
	entry_t               rd_b_q;
	entry_t               fwd_data_q;
	logic                 fwd_a_q;
	logic                 fwd_b_q;
	entry_t               entry_a;
	entry_t               entry_b;
	entry_t               wdata_s1;
	vec_t                 left_q;

	// Pipeline.
	logic                 valid_s1, valid_s2, valid_s3;
	logic                 has_a_s1, has_a_s2, has_a_s3;
	logic                 has_b_s1, has_b_s2, has_b_s3;
	logic                 copy_s1, copy_s2, copy_s3;
	logic                 eog_s1, eog_s2, eog_s3;
	logic [AW-1:0]        col_s1;
	vec_t                 in_s1, in_s2, in_s3;
	vec_t                 centre_s2, centre_s3;
	word_t                stencil_s3 [LANES];
	res_word_t            word_a;
	res_word_t            word_b;
	logic                 extra_s4;
	res_word_t            word_s4;
	push_t                push;

	// APB configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vectors_q <= ROW_VECTORS_RST;
			row_count_q <= ROW_COUNT_RST;
		end else if (cfg_wr) begin
			unique case (paddr[REG_SEL_BIT])
				REG_ROW_VECTORS: row_vectors_q <= pwdata[ROW_VEC_W-1:0];
				REG_ROW_COUNT:   row_count_q <= pwdata[ROW_CNT_W-1:0];
				default:         row_count_q <= row_count_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[REG_SEL_BIT])
			REG_ROW_VECTORS: prdata = APB_DATA_W'(row_vectors_q);
			REG_ROW_COUNT:   prdata = APB_DATA_W'(row_count_q);
			default:         prdata = '0;
		endcase
	end

	// Input word unpacking.
	assign in_lanes[0] = vec_in.lane0_value;
	assign in_lanes[1] = vec_in.lane1_value;
	assign in_lanes[2] = vec_in.lane2_value;
	assign in_lanes[3] = vec_in.lane3_value;
	assign in_lanes[4] = vec_in.lane4_value;
	assign in_lanes[5] = vec_in.lane5_value;
	assign in_lanes[6] = vec_in.lane6_value;
	assign in_lanes[7] = vec_in.lane7_value;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			in_vec[l] = in_lanes[l];
		end
	end

	// A zero width acts as one vector, and widths beyond the store are clipped.
	assign col_inc = PW'(col_q) + PW'(1);
	assign last_col = (col_inc >= PW'(row_vectors_q)) || (col_inc >= PW'(MAX_ROW_VECTORS));
	assign row_inc = (ROW_CNT_W+1)'(row_q) + (ROW_CNT_W+1)'(1);
	assign last_row = (row_inc >= (ROW_CNT_W+1)'(row_count_q));
	assign has_a = (row_q != '0);
	assign has_b = last_row;
	assign is_copy = (row_q == ROW_CNT_W'(1)) || (col_q == '0) || last_col;
	assign rd_b_addr = (col_q == AW'(MAX_ROW_VECTORS - 1)) ? '0 : col_q + AW'(1);
	assign add_words = {1'b0, has_a} + {1'b0, has_b};

	assign accept = vec_in.valid && vec_in.ready;
	assign pop = vec_out.valid && vec_out.ready;
	assign vec_in.ready = !bubble_q && (credit_q <= CRED_W'(OUT_DEPTH - 2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			bubble_q <= 1'b0;
			credit_q <= '0;
		end else begin
			if (accept) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_inc[ROW_CNT_W-1:0];
				end else begin
					col_q <= col_inc[AW-1:0];
				end
			end
			bubble_q <= accept && has_a && has_b;
			credit_q <= credit_q + (accept ? CRED_W'(add_words) : '0) - CRED_W'(pop);
		end
	end

	// Line store: entry per column holds the two previous rows. Reads are issued
	// at acceptance; a write landing on the same edge is forwarded.
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			mem[col_s1] <= wdata_s1;
		end
		if (accept) begin
			rd_a_q <= mem[col_q];
			rd_b_q <= mem[rd_b_addr];
			fwd_a_q <= valid_s1 && (col_s1 == col_q);
			fwd_b_q <= valid_s1 && (col_s1 == rd_b_addr);
			fwd_data_q <= wdata_s1;
		end
	end

	assign entry_a = fwd_a_q ? fwd_data_q : rd_a_q;
	assign entry_b = fwd_b_q ? fwd_data_q : rd_b_q;

	always_comb begin
		wdata_s1.older = entry_a.newer;
		wdata_s1.newer = in_s1;
	end

	// The left neighbor is the centre of the vector just before in this row.
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			left_q <= entry_a.newer;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			has_a_s1 <= 1'b0;
			has_a_s2 <= 1'b0;
			has_a_s3 <= 1'b0;
			has_b_s1 <= 1'b0;
			has_b_s2 <= 1'b0;
			has_b_s3 <= 1'b0;
			extra_s4 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			has_a_s1 <= has_a;
			has_a_s2 <= has_a_s1;
			has_a_s3 <= has_a_s2;
			has_b_s1 <= has_b;
			has_b_s2 <= has_b_s1;
			has_b_s3 <= has_b_s2;
			extra_s4 <= valid_s3 && has_a_s3 && has_b_s3;
		end
	end

	always_ff @(posedge clk) begin
		col_s1 <= col_q;
		in_s1 <= in_vec;
		copy_s1 <= is_copy;
		eog_s1 <= last_col;
		in_s2 <= in_s1;
		centre_s2 <= entry_a.newer;
		copy_s2 <= copy_s1;
		eog_s2 <= eog_s1;
		in_s3 <= in_s2;
		centre_s3 <= centre_s2;
		copy_s3 <= copy_s2;
		eog_s3 <= eog_s2;
		word_s4 <= word_b;
	end

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		jfs_lane_math u_lane_math (
			.clk       (clk),
			.centre    (entry_a.newer[l]),
			.up_nb     (entry_a.older[l]),
			.down_nb   (in_s1[l]),
			.left_nb   (left_q[l]),
			.right_nb  (entry_b.newer[l]),
			.result_s3 (stencil_s3[l])
		);
	end

	// Word from the row above (delayed) and the immediate copy of a last-row vector.
	always_comb begin
		word_a = '0;
		word_b = '0;
		for (int l = 0; l < LANES; l++) begin
			word_a.lanes[l] = copy_s3 ? centre_s3[l] : stencil_s3[l];
			word_b.lanes[l] = in_s3[l];
		end
		word_a.last_of_run = !has_b_s3;
		word_a.end_of_grid = 1'b0;
		word_b.last_of_run = 1'b1;
		word_b.end_of_grid = eog_s3;
	end

	// The cycle after a two-word vector is always a bubble in stage three.
	always_comb begin
		if (extra_s4) begin
			push.valid = 1'b1;
			push.word = word_s4;
		end else begin
			push.valid = valid_s3 && (has_a_s3 || has_b_s3);
			push.word = has_a_s3 ? word_a : word_b;
		end
	end

	jfs_out_fifo u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.dst    (vec_out)
	);
endmodule

FILE: rtl/jfs_lane_math.sv
// One lane of the stencil arithmetic: 4*centre + four neighbors, rounded /8, saturated.
// Two register stages; result valid in the third pipeline stage. Depends on jfs_pkg.
module jfs_lane_math (
	input  logic           clk,
	input  jfs_pkg::word_t centre,
	input  jfs_pkg::word_t up_nb,
	input  jfs_pkg::word_t down_nb,
	input  jfs_pkg::word_t left_nb,
	input  jfs_pkg::word_t right_nb,
	output jfs_pkg::word_t result_s3
);
	import jfs_pkg::*;

	localparam int PAIR_W = WORD_W + 1;
	localparam int SUM_W = WORD_W + 4;
	localparam int QUO_W = SUM_W - 3;

	logic signed [PAIR_W-1:0] vert_sum;
	logic signed [PAIR_W-1:0] horz_sum;
	logic signed [PAIR_W-1:0] vert_s2;
	logic signed [PAIR_W-1:0] horz_s2;
	word_t                    centre_s2;
	logic signed [SUM_W-1:0]  total;
	logic signed [SUM_W-1:0]  total_s3;
	logic signed [QUO_W-1:0]  quot;

	assign vert_sum = PAIR_W'(up_nb) + PAIR_W'(down_nb);
	assign horz_sum = PAIR_W'(left_nb) + PAIR_W'(right_nb);

	always_ff @(posedge clk) begin
		vert_s2 <= vert_sum;
		horz_s2 <= horz_sum;
		centre_s2 <= centre;
	end

	// The +4 bias makes the floor shift round to nearest, ties upward.
	assign total = (SUM_W'(centre_s2) <<< 2) + SUM_W'(vert_s2) + SUM_W'(horz_s2)
		+ SUM_W'(signed'(4));

	always_ff @(posedge clk) begin
		total_s3 <= total;
	end

	assign quot = total_s3[SUM_W-1:3];

	always_comb begin
		if (quot[QUO_W-1] == quot[WORD_W-1]) begin
			result_s3 = quot[WORD_W-1:0];
		end else if (quot[QUO_W-1]) begin
			result_s3 = {1'b1, {(WORD_W-1){1'b0}}};
		end else begin
			result_s3 = {1'b0, {(WORD_W-1){1'b1}}};
		end
	end
endmodule

FILE: rtl/jfs_out_fifo.sv
// Result queue of the stencil unit: register slots, one push and one pop per cycle.
// Drives the output stream; depends on jfs_pkg and jfs_out_if.
module jfs_out_fifo (
	input logic            clk,
	input logic            arst_n,
	input jfs_pkg::push_t  push,
	jfs_out_if.source      dst
);
	import jfs_pkg::*;

	localparam int PTR_W = $clog2(OUT_DEPTH);
	localparam int CNT_W = $clog2(OUT_DEPTH + 1);

	res_word_t         slots_q [OUT_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              pop;
	res_word_t         head;

	assign pop = dst.valid && dst.ready;

	always_ff @(posedge clk) begin
		if (push.valid) begin
			slots_q[wr_ptr_q] <= push.word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push.valid) - CNT_W'(pop);
		end
	end

	assign head = slots_q[rd_ptr_q];

	assign dst.valid = (count_q != '0);
	assign dst.lane0_result = head.lanes[0];
	assign dst.lane1_result = head.lanes[1];
	assign dst.lane2_result = head.lanes[2];
	assign dst.lane3_result = head.lanes[3];
	assign dst.lane4_result = head.lanes[4];
	assign dst.lane5_result = head.lanes[5];
	assign dst.lane6_result = head.lanes[6];
	assign dst.lane7_result = head.lanes[7];
	assign dst.last_of_run = head.last_of_run;
	assign dst.end_of_grid = head.end_of_grid;
endmodule
